[sv/mfd_pkg.sv]
// Shared types and constants for the message frame deframer.
// Used by mfd_core and message_frame_deframer; depends on nothing.
package mfd_pkg;

  localparam int LongLengthBytes = 8;
  localparam int LenW            = 64;
  localparam int ByteW           = 8;
  localparam int CntW            = $clog2(LongLengthBytes);

  localparam logic [ByteW-1:0] LONG_MARK = 8'hff;

  typedef enum logic [2:0] {
    KIND_SHORT = 3'd0,
    KIND_LONG  = 3'd1,
    KIND_FLAGS = 3'd2,
    KIND_BODY  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ByteW-1:0]  data;
    logic [LenW-1:0]   body_length;
    logic              last;
  } result_t;

endpackage

[sv/mfd_core.sv]
// Frame parsing state machine: classifies one byte and advances frame state.
// Depends on mfd_pkg for the result struct, byte kinds and length constants.
module mfd_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [mfd_pkg::ByteW-1:0]  in_byte,
  output mfd_pkg::result_t           result
);
  import mfd_pkg::*;

  typedef enum logic [2:0] {
    PH_SHORT = 3'd0,
    PH_LONG  = 3'd1,
    PH_FLAGS = 3'd2,
    PH_BODY  = 3'd3,
    PH_HALT  = 3'd4
  } phase_t;

  phase_t            phase, phase_next;
  logic [LenW-1:0]   length_shift, length_shift_next;
  logic [CntW-1:0]   long_seen, long_seen_next;
  logic [LenW-1:0]   body_remaining, body_remaining_next;
  logic [LenW-1:0]   body_total, body_total_next;
  logic [LenW-1:0]   shifted;
  logic [LenW-1:0]   remaining_dec;

  assign shifted       = {length_shift[LenW-ByteW-1:0], in_byte};
  assign remaining_dec = body_remaining - LenW'(1);

  always_comb begin
    phase_next          = phase;
    length_shift_next   = length_shift;
    long_seen_next      = long_seen;
    body_remaining_next = body_remaining;
    body_total_next     = body_total;
    result.kind         = KIND_ERROR;
    result.data         = in_byte;
    result.body_length  = '0;
    result.last         = 1'b0;
    case (phase)
      PH_SHORT: begin
        if (in_byte == LONG_MARK) begin
          result.kind       = KIND_LONG;
          length_shift_next = '0;
          long_seen_next    = '0;
          phase_next        = PH_LONG;
        end else if (in_byte == '0) begin
          // empty short frame: flag and keep waiting for a length
          result.kind = KIND_ERROR;
        end else begin
          result.kind     = KIND_SHORT;
          body_total_next = LenW'(in_byte) - LenW'(1);
          phase_next      = PH_FLAGS;
        end
      end
      PH_LONG: begin
        result.kind       = KIND_LONG;
        length_shift_next = shifted;
        if (long_seen == CntW'(LongLengthBytes - 1)) begin
          long_seen_next = '0;
          if (shifted == '0) begin
            // zero long length: halt until reset
            result.kind = KIND_ERROR;
            phase_next  = PH_HALT;
          end else begin
            body_total_next = shifted - LenW'(1);
            phase_next      = PH_FLAGS;
          end
        end else begin
          long_seen_next = long_seen + CntW'(1);
        end
      end
      PH_FLAGS: begin
        result.kind         = KIND_FLAGS;
        result.body_length  = body_total;
        body_remaining_next = body_total;
        if (body_total == '0) begin
          result.last = 1'b1;
          phase_next  = PH_SHORT;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        result.kind         = KIND_BODY;
        result.body_length  = body_total;
        body_remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          result.last = 1'b1;
          phase_next  = PH_SHORT;
        end
      end
      default: begin
        result.kind = KIND_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SHORT;
      length_shift   <= '0;
      long_seen      <= '0;
      body_remaining <= '0;
      body_total     <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      length_shift   <= length_shift_next;
      long_seen      <= long_seen_next;
      body_remaining <= body_remaining_next;
      body_total     <= body_total_next;
    end
  end

endmodule

[sv/message_frame_deframer.sv]
// Top level of the message frame deframer: stream ports and result register.
// Depends on mfd_pkg and mfd_core.
//
//   channel | dir | tdata (low bit up)                      | tuser      | tlast
//   s_*     | in  | in_byte[7:0]                            | -          | -
//   m_*     | out | data_out[7:0], body_length[71:8]        | byte_kind  | frame_last
//
// One byte per clock unless m_tready stalls: each transfer is classified
// in its cycle and the result appears on the master side on the next cycle.
// The single result register sets the latency; a new byte is taken whenever
// the register is empty or being drained in the same cycle.
// A stall on m_tready holds the result and the frame state.
// Synchronous reset returns the block to expecting a length byte.
module message_frame_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // in_byte[7:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [71:0]                   m_tdata,   // data_out[7:0], body_length[71:8]
  output logic [2:0]                    m_tuser,   // byte_kind[2:0]
  output logic                          m_tlast    // frame_last
);
  import mfd_pkg::*;

  logic    accept;
  result_t result;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  mfd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .in_byte (s_tdata),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // load the payload only on a transfer; hold it while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {result.body_length, result.data};
      m_tuser <= 3'(result.kind);
      m_tlast <= result.last;
    end
  end

endmodule

[dv/message_frame_deframer_tb.sv]
// Self-checking testbench for message_frame_deframer: byte streams of short and long frames,
// zero-length errors and a final halt, with random idles on both stream sides.
// Depends on mfd_pkg and the message_frame_deframer RTL.
module message_frame_deframer_tb;
  import mfd_pkg::*;

  localparam int StallLimit = 2000;
  localparam int RandomBytes = 1200;

  typedef enum logic [2:0] {
    AWAIT_LENGTH,
    LONG_LENGTH,
    AWAIT_FLAGS,
    IN_BODY,
    HALTED
  } frame_state_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [63:0] body_length;
    logic        last;
  } byte_result_t;

  class deframe_scoreboard;
    frame_state_t state;
    logic [63:0]  length_acc;
    logic [3:0]   long_count;
    logic [63:0]  body_left;
    logic [63:0]  body_size;
    byte_result_t due[$];
    int           mismatches;

    function new();
      state = AWAIT_LENGTH;
      length_acc = '0;
      long_count = '0;
      body_left = '0;
      body_size = '0;
      mismatches = 0;
    endfunction

    // Classify one accepted byte and queue the result it must produce.
    function void note_byte(logic [7:0] b);
      byte_result_t r;
      r.kind = KIND_ERROR;
      r.data = b;
      r.body_length = '0;
      r.last = 1'b0;
      case (state)
        AWAIT_LENGTH: begin
          if (b == LONG_MARK) begin
            r.kind = KIND_LONG;
            length_acc = '0;
            long_count = '0;
            state = LONG_LENGTH;
          end else if (b != 8'h00) begin
            r.kind = KIND_SHORT;
            body_size = 64'(b) - 64'd1;
            state = AWAIT_FLAGS;
          end
        end
        LONG_LENGTH: begin
          r.kind = KIND_LONG;
          length_acc = {length_acc[55:0], b};
          long_count = long_count + 4'd1;
          if (long_count >= LongLengthBytes) begin
            long_count = '0;
            if (length_acc == '0) begin
              r.kind = KIND_ERROR;
              state = HALTED;
            end else begin
              body_size = length_acc - 64'd1;
              state = AWAIT_FLAGS;
            end
          end
        end
        AWAIT_FLAGS: begin
          r.kind = KIND_FLAGS;
          r.body_length = body_size;
          body_left = body_size;
          if (body_size == '0) begin
            r.last = 1'b1;
            state = AWAIT_LENGTH;
          end else begin
            state = IN_BODY;
          end
        end
        IN_BODY: begin
          r.kind = KIND_BODY;
          r.body_length = body_size;
          body_left = body_left - 64'd1;
          if (body_left == '0) begin
            r.last = 1'b1;
            state = AWAIT_LENGTH;
          end
        end
        default: ;
      endcase
      due.push_back(r);
    endfunction

    function void check_result(logic [2:0] kind, logic [7:0] data, logic [63:0] blen,
                               logic last);
      byte_result_t e;
      if (due.size() == 0) begin
        $display("%0t: result with nothing due: kind %0d data %h", $time, kind, data);
        mismatches++;
        return;
      end
      e = due.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: byte_kind expected %0d actual %0d", $time, e.kind, kind);
        mismatches++;
      end
      if (data !== e.data) begin
        $display("%0t: data_out expected %h actual %h", $time, e.data, data);
        mismatches++;
      end
      if (blen !== e.body_length) begin
        $display("%0t: body_length expected %0d actual %0d", $time, e.body_length, blen);
        mismatches++;
      end
      if (last !== e.last) begin
        $display("%0t: frame_last expected %b actual %b", $time, e.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  deframe_scoreboard sb;
  bit steady = 1'b0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  message_frame_deframer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one byte, idling first at random, and hold it until the transfer.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Length prefix, flags byte, then len-1 random body bytes.
  task automatic send_frame(input logic [63:0] len, input bit use_long);
    logic [63:0] i;
    if (use_long) begin
      send_byte(LONG_MARK);
      for (int k = 7; k >= 0; k--) send_byte(len[8*k +: 8]);
    end else begin
      send_byte(len[7:0]);
    end
    send_byte(8'($urandom));
    for (i = 64'd1; i < len; i++) send_byte(8'($urandom));
  endtask

  function automatic logic [63:0] pick_length(bit use_long);
    int r;
    r = $urandom_range(99);
    if (r < 6) return 64'd1;
    if (r < 10) return use_long ? 64'($urandom_range(255, 600)) : 64'd254;
    if (r < 15) return 64'($urandom_range(1, 254));
    return 64'($urandom_range(1, 16));
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[7:0], m_tdata[71:8], m_tlast);
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero short length, empty bodies, extreme body bytes, long form.
    send_byte(8'h00);
    send_frame(64'd1, 1'b0);
    send_byte(8'd3);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame(64'd1, 1'b1);
    send_byte(8'd2);
    send_byte(8'hff);
    send_byte(8'ha5);
    send_frame(64'd3, 1'b1);

    // Random frames with some zero-length noise; a middle stretch runs without idles.
    while (bytes_sent < RandomBytes) begin
      int r;
      bit use_long;
      steady = (bytes_sent >= 500 && bytes_sent < 800);
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'h00);
      end else begin
        use_long = (r >= 65);
        send_frame(pick_length(use_long), use_long);
      end
    end
    steady = 1'b0;

    // Zero long length halts the block; everything after must come back as errors.
    send_byte(LONG_MARK);
    repeat (8) send_byte(8'h00);
    repeat (6) send_byte(8'($urandom));
    send_byte(8'hff);
    send_byte(8'd3);
    s_tvalid <= 1'b0;

    while (sb.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mfd_pkg.sv
sv/mfd_core.sv
sv/message_frame_deframer.sv
dv/message_frame_deframer_tb.sv
